>>> rtl/core/mcsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_pkg: shared types and constants for the multi-channel servo PWM
// Operation codes, register indexes, reset values, fixed-point reciprocal
// constants and the structs that travel between the pipeline and the cells.
// ----------------------------------------------------------------------------
package mcsp_pkg;

  localparam int MAX_CH         = 8;
  localparam int CH_IDX_W       = 3;
  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_FRAME_MS   = 20;
  localparam int FRAME_W        = 17;   // FRAME_MS * counts_per_ms before saturation
  localparam int FIFO_DEPTH     = 8;

  // Register indexes of the configuration port
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_COUNTS_PER_MS = 1'b1;

  // Reset values
  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd8;
  localparam logic [11:0] RST_COUNTS_PER_MS = 12'd2000;
  localparam logic [15:0] RST_ACTIVE        = 16'd3000;
  localparam logic [15:0] RST_MIN_COUNTS    = 16'd1600;
  localparam logic [15:0] RST_MAX_COUNTS    = 16'd4400;

  // Microseconds to counts: floor(p / 1000) = (p * US_RECIP) >> US_SHIFT, p < 2^27
  localparam int              US_PROD_W  = 27;
  localparam int              US_RECIP_W = 28;
  localparam logic [27:0]     US_RECIP   = 28'd137438954;
  localparam int              US_SHIFT   = 37;
  localparam int              US_Q_W     = 18;

  // Degrees: floor(s / 180) = (s * DEG_RECIP) >> DEG_SHIFT, 0 <= s < 2^24
  localparam int              SUM_W       = 26;
  localparam int              DEG_DIV_W   = 24;
  localparam int              DEG_RECIP_W = 25;
  localparam logic [24:0]     DEG_RECIP   = 25'd23860930;
  localparam int              DEG_SHIFT   = 32;
  localparam int              DEG_Q_W     = 17;
  localparam logic [7:0]      DEG_FULL    = 8'd180;
  // Sums at or below -180 truncate to a negative width and are dropped
  localparam logic signed [25:0] ANGLE_FLOOR = -26'sd179;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_ANGLE = 2'd1,
    OP_SET_US    = 2'd2,
    OP_CALIBRATE = 2'd3
  } op_t;

  typedef struct packed {
    logic                we;
    logic [CH_IDX_W-1:0] ch;
    logic [15:0]         min_cnt;
    logic [15:0]         max_cnt;
  } cal_cmd_t;

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [CH_IDX_W-1:0] ch;
    logic                pend_we;
    logic [15:0]         width;
  } commit_t;

  typedef struct packed {
    logic        tick;
    logic        first;
    logic [15:0] count;
  } tick_t;

  typedef struct packed {
    logic [7:0] pins;
    logic       frame_start;
  } out_item_t;

endpackage

>>> rtl/core/mcsp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_cell: one servo channel
// Holds the channel's pin, active and shadow widths and calibration, and
// passes the running pin status on to the next cell of the row.
// ----------------------------------------------------------------------------
module mcsp_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  mcsp_pkg::tick_t    tick,
  input  mcsp_pkg::commit_t  cmt,
  input  mcsp_pkg::cal_cmd_t cal,
  input  logic               xfer,
  input  logic               any_in,
  input  logic               was_in,
  output logic               any_out,
  output logic               was_out,
  output logic               level_next,
  output logic [15:0]        min_cnt,
  output logic [15:0]        max_cnt,
  output logic               pend_valid
);
  import mcsp_pkg::*;

  logic        pin;
  logic [15:0] active;
  logic [15:0] pending;
  logic        lv;
  logic        pend_wr;
  logic        cal_wr;

  assign pend_wr = cmt.valid && cmt.pend_we && (cmt.ch == CH_IDX_W'(IDX));
  assign cal_wr  = cal.we && (cal.ch == CH_IDX_W'(IDX));

  always_comb begin
    lv         = (tick.first ? en : (pin & en)) & (tick.count < active);
    level_next = tick.tick ? lv : pin;
    any_out    = any_in | lv;
    was_out    = was_in | (pin & en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin        <= 1'b0;
      active     <= RST_ACTIVE;
      pend_valid <= 1'b0;
      min_cnt    <= RST_MIN_COUNTS;
      max_cnt    <= RST_MAX_COUNTS;
    end else begin
      if (tick.tick) begin
        pin <= lv;
      end
      if (xfer && pend_valid) begin
        active     <= pending;
        pend_valid <= 1'b0;
      end else if (pend_wr) begin
        pend_valid <= 1'b1;
      end
      if (cal_wr) begin
        min_cnt <= cal.min_cnt;
        max_cnt <= cal.max_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_wr) begin
      pending <= cmt.width;
    end
  end

endmodule

>>> rtl/core/mcsp_width_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_width_pipe: width conversion pipeline
// Six register stages: operand capture, count product, divide by 1000,
// calibration write and angle product, angle sum, divide by 180.
// ----------------------------------------------------------------------------
module mcsp_width_pipe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_acc,
  input  mcsp_pkg::op_t          op_in,
  input  logic [2:0]             ch_in,
  input  logic [7:0]             angle_in,
  input  logic [14:0]            pulse_in,
  input  logic [14:0]            min_in,
  input  logic [14:0]            max_in,
  input  logic [11:0]            eff_cpm,
  input  logic [3:0]             eff_ch,
  input  logic [15:0]            width_top,
  output mcsp_pkg::cal_cmd_t     cal,
  input  logic [15:0]            cal_lo,
  input  logic [15:0]            cal_hi,
  output mcsp_pkg::commit_t      cmt
);
  import mcsp_pkg::*;

  localparam int US_MUL_W  = US_PROD_W + US_RECIP_W;
  localparam int DEG_MUL_W = DEG_DIV_W + DEG_RECIP_W;

  // stage 1: operands
  logic                v1;
  op_t                 op1;
  logic [CH_IDX_W-1:0] ch1;
  logic [7:0]          ang1;
  logic [14:0]         pu1, mn1, mx1;
  // stage 2: count products
  logic                v2;
  op_t                 op2;
  logic [CH_IDX_W-1:0] ch2;
  logic [7:0]          ang2;
  logic [US_PROD_W-1:0] pa2, pb2;
  // stage 3: counts
  logic                v3;
  op_t                 op3;
  logic [CH_IDX_W-1:0] ch3;
  logic [7:0]          ang3;
  logic [US_Q_W-1:0]   qa3, qb3;
  // stage 4: angle product
  logic                v4;
  op_t                 op4;
  logic [CH_IDX_W-1:0] ch4;
  logic signed [SUM_W-1:0] prod4;
  logic [DEG_DIV_W-1:0] lo180_4;
  logic [US_Q_W-1:0]   us4;
  // stage 5: angle sum
  logic                v5;
  op_t                 op5;
  logic [CH_IDX_W-1:0] ch5;
  logic signed [SUM_W-1:0] sum5;
  logic [US_Q_W-1:0]   us5;
  // stage 6: raw width
  logic                v6;
  op_t                 op6;
  logic [CH_IDX_W-1:0] ch6;
  logic                pend_we6;
  logic [US_Q_W-1:0]   raw6;

  logic [14:0]          sel_a;
  logic [US_MUL_W-1:0]  mul_a, mul_b;
  logic signed [16:0]   diff;
  logic signed [SUM_W-1:0] ang_s, diff_s;
  logic [DEG_MUL_W-1:0] mul_d;
  logic [DEG_Q_W-1:0]   quo;
  logic                 ang_ok;

  function automatic logic in_range(logic [CH_IDX_W-1:0] ch, logic [3:0] lim);
    return {1'b0, ch} < lim;
  endfunction

  function automatic logic [15:0] sat16(logic [US_Q_W-1:0] q);
    return (q > US_Q_W'(16'hFFFF)) ? 16'hFFFF : q[15:0];
  endfunction

  always_comb begin
    sel_a  = (op1 == OP_CALIBRATE) ? mn1 : pu1;
    mul_a  = US_MUL_W'(pa2) * US_MUL_W'(US_RECIP);
    mul_b  = US_MUL_W'(pb2) * US_MUL_W'(US_RECIP);
    diff   = $signed({1'b0, cal_hi}) - $signed({1'b0, cal_lo});
    ang_s  = {{(SUM_W-8){1'b0}}, ang3};
    diff_s = {{(SUM_W-17){diff[16]}}, diff};
    mul_d  = DEG_MUL_W'(sum5[DEG_DIV_W-1:0]) * DEG_MUL_W'(DEG_RECIP);
    quo    = sum5[SUM_W-1] ? '0 : mul_d[DEG_SHIFT +: DEG_Q_W];
    ang_ok = !(sum5 < ANGLE_FLOOR);
  end

  // Calibration is written where the angle path reads it, so order holds
  always_comb begin
    cal.we      = v3 && (op3 == OP_CALIBRATE) && in_range(ch3, eff_ch);
    cal.ch      = ch3;
    cal.min_cnt = sat16(qa3);
    cal.max_cnt = sat16(qb3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= in_acc;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= op_in;
    ch1  <= ch_in;
    ang1 <= angle_in;
    pu1  <= pulse_in;
    mn1  <= min_in;
    mx1  <= max_in;

    op2  <= op1;
    ch2  <= ch1;
    ang2 <= ang1;
    pa2  <= US_PROD_W'(sel_a) * US_PROD_W'(eff_cpm);
    pb2  <= US_PROD_W'(mx1) * US_PROD_W'(eff_cpm);

    op3  <= op2;
    ch3  <= ch2;
    ang3 <= ang2;
    qa3  <= mul_a[US_SHIFT +: US_Q_W];
    qb3  <= mul_b[US_SHIFT +: US_Q_W];

    op4     <= op3;
    ch4     <= ch3;
    prod4   <= ang_s * diff_s;
    lo180_4 <= DEG_DIV_W'(cal_lo) * DEG_DIV_W'(DEG_FULL);
    us4     <= qa3;

    op5  <= op4;
    ch5  <= ch4;
    sum5 <= prod4 + $signed({{(SUM_W-DEG_DIV_W){1'b0}}, lo180_4});
    us5  <= us4;

    op6      <= op5;
    ch6      <= ch5;
    raw6     <= (op5 == OP_SET_ANGLE) ? US_Q_W'(quo) : us5;
    pend_we6 <= in_range(ch5, eff_ch) &&
                (((op5 == OP_SET_ANGLE) && ang_ok) || (op5 == OP_SET_US));
  end

  // Saturate to 1..frame-1 on the way out
  always_comb begin
    cmt.valid   = v6;
    cmt.op      = op6;
    cmt.ch      = ch6;
    cmt.pend_we = pend_we6;
    if (raw6 > US_Q_W'(width_top)) begin
      cmt.width = width_top;
    end else if (raw6 == '0) begin
      cmt.width = 16'd1;
    end else begin
      cmt.width = raw6[15:0];
    end
  end

endmodule

>>> rtl/core/mcsp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_out_fifo: result queue
// Small register queue that holds finished results until the output side
// takes them.
// ----------------------------------------------------------------------------
module mcsp_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mcsp_pkg::out_item_t wr_item,
  input  logic                pop,
  output logic                valid,
  output mcsp_pkg::out_item_t rd_item,
  output logic                full
);
  import mcsp_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  out_item_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [LVL_W-1:0] level;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign valid   = (level != '0);
  assign full    = (level == LVL_W'(FIFO_DEPTH));
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= bump(wp);
      end
      if (pop) begin
        rp <= bump(rp);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

endmodule

>>> rtl/core/multi_channel_servo_pwm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_servo_pwm: multi-channel servo pulse generator
// Ticks advance a shared frame counter; every enabled pin rises at frame
// start and falls when the counter reaches its width. Set and calibrate
// transactions convert to tick counts; set transactions queue shadow widths.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        slave      in_valid / in_stall      operation channel angle pulse_us
//                                                min_us max_us
//  out       master     out_valid / out_stall    pins frame_start
//  cfg       slave      cfg_write                cfg_index cfg_data
//
//  One transaction per cycle while in_stall is low, set and calibrate included.
//  A result passes six register stages of width arithmetic (two dependent
//  multiplies per divide) and then the result queue before it is visible.
//  in_stall rises when eight transactions are accepted but not yet taken,
//  the depth of the result queue; out_stall never blocks the pipeline.
//  Synchronous active-high reset; no clearing pass after reset.
// ----------------------------------------------------------------------------
module multi_channel_servo_pwm #(
  parameter int CHANNELS = mcsp_pkg::DEF_CHANNELS,
  parameter int FRAME_MS = mcsp_pkg::DEF_FRAME_MS
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [2:0]  channel,
  input  logic [7:0]  angle,
  input  logic [14:0] pulse_us,
  input  logic [14:0] min_us,
  input  logic [14:0] max_us,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pins,
  output logic        frame_start,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import mcsp_pkg::*;

  localparam int         CREDIT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [7:0] PIN_MASK = 8'((1 << CHANNELS) - 1);

  // configuration registers
  logic [3:0]  channel_count;
  logic [11:0] counts_per_ms;

  // derived configuration
  logic [3:0]         eff_ch;
  logic [11:0]        eff_cpm;
  logic [FRAME_W-1:0] frame_full;
  logic [15:0]        frame_len;
  logic [15:0]        width_top;
  logic [MAX_CH-1:0]  en;

  // handshake and credit
  logic                in_acc, out_acc;
  logic [CREDIT_W-1:0] credit, credit_next;

  // pipeline and cells
  cal_cmd_t    cal;
  commit_t     cmt;
  tick_t       tick;
  logic [15:0] tick_counter, tick_counter_next;
  logic        wrap;
  logic        xfer;
  logic [15:0] cal_lo, cal_hi;
  logic [15:0] min_vals [MAX_CH];
  logic [15:0] max_vals [MAX_CH];
  logic [MAX_CH-1:0] level_next;
  logic [MAX_CH-1:0] pend_vec;
  logic [CHANNELS:0] any_chain, was_chain;

  // result queue
  out_item_t wr_item, rd_item;
  logic      fifo_full;

  // --------------------------------------------------------------------------
  // Configuration: a write lands at once, derived values follow combinationally
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= RST_CHANNEL_COUNT;
      counts_per_ms <= RST_COUNTS_PER_MS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[3:0];
        REG_COUNTS_PER_MS: counts_per_ms <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_comb begin
    // zero channels act as one, too many act as the number of cells
    if (channel_count == 4'd0) begin
      eff_ch = 4'd1;
    end else if (channel_count > 4'(CHANNELS)) begin
      eff_ch = 4'(CHANNELS);
    end else begin
      eff_ch = channel_count;
    end
    eff_cpm    = (counts_per_ms == 12'd0) ? 12'd1 : counts_per_ms;
    frame_full = FRAME_W'(eff_cpm) * FRAME_W'(FRAME_MS);
    frame_len  = (frame_full > FRAME_W'(16'hFFFF)) ? 16'hFFFF : frame_full[15:0];
    width_top  = frame_len - 16'd1;
    for (int i = 0; i < MAX_CH; i++) begin
      en[i] = (i < CHANNELS) && (4'(i) < eff_ch);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: admit a transaction only while the queue has a free slot for it
  // --------------------------------------------------------------------------
  assign in_stall = (credit == CREDIT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  always_comb begin
    credit_next = credit + CREDIT_W'(in_acc) - CREDIT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit_next;
    end
  end

  // --------------------------------------------------------------------------
  // Width arithmetic
  // --------------------------------------------------------------------------
  mcsp_width_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_acc    (in_acc),
    .op_in     (op_t'(operation)),
    .ch_in     (channel),
    .angle_in  (angle),
    .pulse_in  (pulse_us),
    .min_in    (min_us),
    .max_in    (max_us),
    .eff_cpm   (eff_cpm),
    .eff_ch    (eff_ch),
    .width_top (width_top),
    .cal       (cal),
    .cal_lo    (cal_lo),
    .cal_hi    (cal_hi),
    .cmt       (cmt)
  );

  // calibration read for the angle path, same stage as the calibration write
  assign cal_lo = min_vals[cal.ch];
  assign cal_hi = max_vals[cal.ch];

  // --------------------------------------------------------------------------
  // Frame counter: wrap after frame-1, or at once if the frame shrank below it
  // --------------------------------------------------------------------------
  always_comb begin
    tick.tick  = cmt.valid && (cmt.op == OP_TICK);
    tick.first = (tick_counter == 16'd0);
    tick.count = tick_counter;
    wrap       = ({1'b0, tick_counter} + 17'd1) >= {1'b0, frame_len};
    tick_counter_next = wrap ? 16'd0 : tick_counter + 16'd1;
    // shadow widths go live when the last enabled pin falls, or at frame end
    xfer = tick.tick && ((was_chain[CHANNELS] && !any_chain[CHANNELS]) || wrap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
    end else if (tick.tick) begin
      tick_counter <= tick_counter_next;
    end
  end

  // --------------------------------------------------------------------------
  // Row of channel cells; pin status ripples from the lowest cell upward
  // --------------------------------------------------------------------------
  assign any_chain[0] = 1'b0;
  assign was_chain[0] = 1'b0;

  for (genvar g = 0; g < MAX_CH; g++) begin : g_cell
    if (g < CHANNELS) begin : g_on
      mcsp_cell #(
        .IDX (g)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .en         (en[g]),
        .tick       (tick),
        .cmt        (cmt),
        .cal        (cal),
        .xfer       (xfer),
        .any_in     (any_chain[g]),
        .was_in     (was_chain[g]),
        .any_out    (any_chain[g+1]),
        .was_out    (was_chain[g+1]),
        .level_next (level_next[g]),
        .min_cnt    (min_vals[g]),
        .max_cnt    (max_vals[g]),
        .pend_valid (pend_vec[g])
      );
    end else begin : g_off
      // no cell: pin held low, calibration reads as zero
      assign level_next[g] = 1'b0;
      assign min_vals[g]   = 16'd0;
      assign max_vals[g]   = 16'd0;
      assign pend_vec[g]   = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: every transaction leaves one result, in order
  // --------------------------------------------------------------------------
  always_comb begin
    wr_item.pins        = level_next;
    wr_item.frame_start = tick.tick && tick.first;
  end

  mcsp_out_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmt.valid),
    .wr_item (wr_item),
    .pop     (out_acc),
    .valid   (out_valid),
    .rd_item (rd_item),
    .full    (fifo_full)
  );

  assign pins        = rd_item.pins;
  assign frame_start = rd_item.frame_start;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pins_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pins & ~PIN_MASK) == 8'd0))
    else $error("pin driven beyond the instantiated channels");

  a_xfer_clears: assert property (@(posedge clk) disable iff (rst)
    xfer |=> (pend_vec == '0))
    else $error("shadow width left pending after transfer");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= CREDIT_W'(FIFO_DEPTH))
    else $error("outstanding transaction count above queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmt.valid |-> !fifo_full)
    else $error("result pushed into a full queue");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multi-channel servo PWM
// Sends tick, set-angle, set-microseconds and calibrate transactions under
// eight register settings. A scoreboard predicts pin levels and frame starts
// from its own frame counter, shadow widths and calibrations, then checks
// every result in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mcsp_pkg::*;

  localparam int     PIPE_LATENCY = 6;
  localparam int     STALL_LIMIT  = 4000;
  localparam int     MAX_REPORTS  = 10;
  localparam longint SWEEP_DEG    = 180;
  localparam longint US_PER_MS    = 1000;
  localparam longint COUNT_TOP    = 65535;

  // Scoreboard: mirrors the frame counter, pin levels, active and shadow
  // widths and per-channel calibration, and holds the expected results.
  class servo_scoreboard;
    logic [3:0]  chan_reg;
    logic [11:0] cpm_reg;
    logic [15:0] frame_pos;
    logic [7:0]  levels;
    logic [15:0] active_w  [MAX_CH];
    logic [15:0] shadow_w  [MAX_CH];
    logic        shadow_v  [MAX_CH];
    logic [15:0] lo_counts [MAX_CH];
    logic [15:0] hi_counts [MAX_CH];
    out_item_t   expected_levels [$];
    int          mismatches, commands, checked, frames, transfers, angle_drops;

    function new();
      chan_reg  = RST_CHANNEL_COUNT;
      cpm_reg   = RST_COUNTS_PER_MS;
      frame_pos = '0;
      levels    = '0;
      for (int i = 0; i < MAX_CH; i++) begin
        active_w[i]  = RST_ACTIVE;
        shadow_w[i]  = '0;
        shadow_v[i]  = 1'b0;
        lo_counts[i] = RST_MIN_COUNTS;
        hi_counts[i] = RST_MAX_COUNTS;
      end
    endfunction

    function void write_register(logic idx, logic [11:0] data);
      if (idx == REG_CHANNEL_COUNT) chan_reg = data[3:0];
      else cpm_reg = data;
    endfunction

    function int unsigned live_channels();
      if (chan_reg == 0) return 1;
      if (chan_reg > DEF_CHANNELS) return DEF_CHANNELS;
      return chan_reg;
    endfunction

    function longint ticks_per_ms();
      return (cpm_reg == 0) ? 1 : longint'(cpm_reg);
    endfunction

    function longint frame_ticks();
      longint f;
      f = DEF_FRAME_MS * ticks_per_ms();
      return (f > COUNT_TOP) ? COUNT_TOP : f;
    endfunction

    function logic [7:0] enabled_pins();
      logic [8:0] m;
      m = (9'd1 << live_channels()) - 9'd1;
      return m[7:0];
    endfunction

    function logic [15:0] clamp_width(longint w);
      longint top;
      top = frame_ticks() - 1;
      if (w > top) w = top;
      if (w < 1) w = 1;
      return w[15:0];
    endfunction

    function logic [15:0] us_to_ticks(logic [14:0] us);
      longint c;
      c = longint'(us) * ticks_per_ms() / US_PER_MS;
      return (c > COUNT_TOP) ? 16'hFFFF : c[15:0];
    endfunction

    function void promote_shadows();
      bit moved;
      moved = 1'b0;
      for (int i = 0; i < MAX_CH; i++) begin
        if (shadow_v[i]) begin
          active_w[i] = shadow_w[i];
          shadow_v[i] = 1'b0;
          moved       = 1'b1;
        end
      end
      if (moved) transfers++;
    endfunction

    // Advance the mirrored state by one accepted transaction and queue the
    // result it must produce.
    function void note_command(op_t op, logic [2:0] ch, logic [7:0] ang,
                               logic [14:0] pulse, logic [14:0] mn, logic [14:0] mx);
      out_item_t  exp_item;
      logic [7:0] mask, lv;
      longint     c, w;
      bit         was_high, wrap;
      mask = enabled_pins();
      exp_item.frame_start = 1'b0;
      commands++;
      if (op == OP_TICK) begin
        c        = frame_pos;
        was_high = (levels & mask) != 0;
        lv       = levels & mask;
        if (c == 0) begin
          lv = mask;
          exp_item.frame_start = 1'b1;
          frames++;
        end
        for (int i = 0; i < MAX_CH; i++)
          if (c >= active_w[i]) lv[i] = 1'b0;
        lv &= mask;
        levels    = lv;
        wrap      = (c + 1 >= frame_ticks());
        frame_pos = wrap ? 16'd0 : 16'(c + 1);
        if ((was_high && lv == 0) || wrap) promote_shadows();
      end else if (ch < live_channels()) begin
        case (op)
          OP_SET_ANGLE: begin
            // linear between the calibrated ends, truncated toward zero
            w = (longint'(ang) * (longint'(hi_counts[ch]) - longint'(lo_counts[ch]))
                 + SWEEP_DEG * longint'(lo_counts[ch])) / SWEEP_DEG;
            if (w >= 0) begin
              shadow_w[ch] = clamp_width(w);
              shadow_v[ch] = 1'b1;
            end else begin
              angle_drops++;
            end
          end
          OP_SET_US: begin
            w = longint'(pulse) * ticks_per_ms() / US_PER_MS;
            shadow_w[ch] = clamp_width(w);
            shadow_v[ch] = 1'b1;
          end
          OP_CALIBRATE: begin
            lo_counts[ch] = us_to_ticks(mn);
            hi_counts[ch] = us_to_ticks(mx);
          end
          default: ;
        endcase
      end
      exp_item.pins = levels;
      expected_levels.push_back(exp_item);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_levels(logic [7:0] pins_seen, logic fs_seen);
      out_item_t want;
      if (expected_levels.size() == 0) begin
        flag($sformatf("unexpected result pins=%02h frame_start=%0b", pins_seen, fs_seen));
        return;
      end
      want = expected_levels.pop_front();
      checked++;
      if (pins_seen !== want.pins)
        flag($sformatf("pins expected %02h got %02h", want.pins, pins_seen));
      if (fs_seen !== want.frame_start)
        flag($sformatf("frame_start expected %0b got %0b", want.frame_start, fs_seen));
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  operation   = OP_TICK;
  logic [2:0]  channel     = '0;
  logic [7:0]  angle       = '0;
  logic [14:0] pulse_us    = '0;
  logic [14:0] min_us      = '0;
  logic [14:0] max_us      = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  pins;
  logic        frame_start;
  logic        cfg_write   = 1'b0;
  logic        cfg_index   = REG_CHANNEL_COUNT;
  logic [11:0] cfg_data    = '0;

  servo_scoreboard board = new();

  int idle_run     = 0;
  int random_sent  = 0;
  int snd_idle_pct = 11;
  int rcv_idle_pct = 60;

  multi_channel_servo_pwm dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .channel     (channel),
    .angle       (angle),
    .pulse_us    (pulse_us),
    .min_us      (min_us),
    .max_us      (max_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pins        (pins),
    .frame_start (frame_start),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Monitor both channels at the edge: the values seen here are the ones
  // the block sampled, since every driver updates with nonblocking writes.
  // Also randomize the receiver stall and track cycles without progress.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    if (!rst) begin
      if (in_valid && !in_stall)
        board.note_command(op_t'(operation), channel, angle, pulse_us, min_us, max_us);
      if (out_valid && !out_stall)
        board.check_levels(pins, frame_start);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
  end

  // Watchdog: end the run if the block stops moving transactions.
  initial begin
    wait (idle_run >= STALL_LIMIT);
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("[multi_channel_servo_pwm] ERROR");
    $finish;
  end

  // Offer one transaction, after a random sender gap, and hold it until
  // the edge that accepts it.
  task automatic push_item(input op_t op, input logic [2:0] ch, input logic [7:0] ang,
                           input logic [14:0] pulse, input logic [14:0] mn,
                           input logic [14:0] mx);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    channel   <= ch;
    angle     <= ang;
    pulse_us  <= pulse;
    min_us    <= mn;
    max_us    <= mx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every expected result has come out, then let
  // the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_levels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Write both registers while the block is idle. Upper data bits of the
  // channel count are noise that the register must drop.
  task automatic configure(input logic [3:0] count, input logic [11:0] tpm);
    logic [11:0] count_word;
    drain();
    count_word = {8'($urandom), count};
    cfg_write <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data  <= count_word;
    board.write_register(REG_CHANNEL_COUNT, count_word);
    @(posedge clk);
    cfg_index <= REG_COUNTS_PER_MS;
    cfg_data  <= tpm;
    board.write_register(REG_COUNTS_PER_MS, tpm);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly in-range microseconds, with extremes and full 15-bit noise.
  function automatic logic [14:0] pick_us();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 15'($urandom);
    if (r == 1) return 15'd0;
    if (r == 2) return 15'd20000;
    return 15'($urandom_range(0, 20000));
  endfunction

  // Random transactions, mostly ticks so frames advance and shadows move.
  // Idling: sender light / receiver heavy, then swapped, then none.
  task automatic random_burst(input int n);
    int unsigned r;
    op_t         op;
    repeat (n) begin
      if (random_sent < 250) begin
        snd_idle_pct = 11;
        rcv_idle_pct = 60;
      end else if (random_sent < 500) begin
        snd_idle_pct = 60;
        rcv_idle_pct = 11;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      r  = $urandom_range(0, 99);
      op = (r < 64) ? OP_TICK : (r < 76) ? OP_SET_ANGLE : (r < 88) ? OP_SET_US : OP_CALIBRATE;
      push_item(op, 3'($urandom), 8'($urandom), pick_us(), pick_us(), pick_us());
      random_sent++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, 20 ms frame of 40000 ticks
    push_item(OP_TICK, 3'd0, 8'd0, 15'd0, 15'd0, 15'd0);           // frame start
    push_item(OP_TICK, 3'd7, 8'd255, 15'h7FFF, 15'h7FFF, 15'h7FFF); // payload ignored
    push_item(OP_SET_ANGLE, 3'd0, 8'd0, 15'd0, 15'd0, 15'd0);
    push_item(OP_SET_ANGLE, 3'd1, 8'd180, 15'd0, 15'd0, 15'd0);
    push_item(OP_SET_ANGLE, 3'd2, 8'd255, 15'd0, 15'd0, 15'd0);   // past the max end
    push_item(OP_SET_US, 3'd3, 8'd0, 15'd0, 15'd0, 15'd0);         // saturate up to 1
    push_item(OP_SET_US, 3'd4, 8'd0, 15'd20000, 15'd0, 15'd0);     // saturate to frame-1
    push_item(OP_SET_US, 3'd5, 8'd0, 15'h7FFF, 15'd0, 15'd0);
    push_item(OP_CALIBRATE, 3'd6, 8'd0, 15'd0, 15'd0, 15'd20000);
    push_item(OP_SET_ANGLE, 3'd6, 8'd90, 15'd0, 15'd0, 15'd0);
    push_item(OP_CALIBRATE, 3'd7, 8'd0, 15'd0, 15'd1, 15'd0);      // min above max
    push_item(OP_SET_ANGLE, 3'd7, 8'd255, 15'd0, 15'd0, 15'd0);   // truncates to zero
    push_item(OP_CALIBRATE, 3'd7, 8'd0, 15'd0, 15'd5, 15'd0);
    push_item(OP_SET_ANGLE, 3'd7, 8'd255, 15'd0, 15'd0, 15'd0);   // negative, dropped
    push_item(OP_CALIBRATE, 3'd0, 8'd0, 15'd0, 15'h7FFF, 15'h7FFF);
    push_item(OP_SET_ANGLE, 3'd0, 8'd255, 15'd0, 15'd0, 15'd0);
    push_item(OP_CALIBRATE, 3'd1, 8'd0, 15'd0, 15'd20000, 15'd0);
    push_item(OP_SET_ANGLE, 3'd1, 8'd180, 15'd0, 15'd0, 15'd0);
    push_item(OP_SET_ANGLE, 3'd1, 8'd255, 15'd0, 15'd0, 15'd0);   // negative, dropped
    repeat (3) push_item(OP_TICK, 3'd0, 8'd0, 15'd0, 15'd0, 15'd0);

    // Random phases; small frames first so the counter often lies past
    // the end when the frame shrinks, then the extremes of both registers.
    configure(4'd3, 12'd5);     random_burst(170);
    configure(4'd0, 12'd1);     random_burst(110);
    configure(4'd15, 12'd0);    random_burst(110);
    configure(4'd8, 12'd4095);  random_burst(40);
    configure(4'd5, 12'd7);     random_burst(150);
    configure(4'd8, 12'd3276);  random_burst(30);
    configure(4'd2, 12'd10);    random_burst(140);

    drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    $display("covered %0d transactions under 8 register settings: %0d frames begun,",
             board.commands, board.frames);
    $display("%0d shadow transfers, %0d negative angles dropped, %0d results compared",
             board.transfers, board.angle_drops, board.checked);
    if (board.mismatches == 0 && board.expected_levels.size() == 0) begin
      $display("[multi_channel_servo_pwm] OK");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("[multi_channel_servo_pwm] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/mcsp_pkg.sv
rtl/core/mcsp_cell.sv
rtl/core/mcsp_width_pipe.sv
rtl/core/mcsp_out_fifo.sv
rtl/core/multi_channel_servo_pwm.sv
bench/testbench.sv
